### rtl/core/lie_pkg.sv
// Shared types and constants for the line input editor.
// Depends on nothing; imported by the top level and the output register.
package lie_pkg;

  // Terminal control codes
  localparam logic [7:0] CHAR_BS  = 8'h08;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_DEL = 8'h7F;

  // Result kind carried on tuser
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  localparam int LEN_W = 5;

  // One result beat
  typedef struct packed {
    logic [7:0]       data;
    logic             kind;
    logic [LEN_W-1:0] len;
    logic             last;
  } out_beat_t;

endpackage

### rtl/core/lie_line_ram.sv
// Line store: single-port-write, single-port-read memory, registered read data.
// Depends on nothing; used by line_input_editor.
module lie_line_ram #(
  parameter int DEPTH = 31,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/lie_out_reg.sv
// Output register for result beats, parting the sequencer from the receiver.
// Depends on lie_pkg; used by line_input_editor.
module lie_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  lie_pkg::out_beat_t push_beat,
  output logic               push_ready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata,  // [7:0] out_byte, [12:8] line_length, [15:13] zero
  output logic               out_tuser,  // [0] out_kind
  output logic               out_tlast
);
  import lie_pkg::*;

  logic      valid_r;
  out_beat_t beat_r;

  assign push_ready = !valid_r || out_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push_ready) begin
      valid_r <= push_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push_ready && push_valid) begin
      beat_r <= push_beat;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {3'b000, beat_r.len, beat_r.data};
  assign out_tuser  = beat_r.kind;
  assign out_tlast  = beat_r.last;

endmodule

### rtl/core/line_input_editor.sv
// Top level of the terminal line editor with backspace and echo.
// Depends on lie_pkg, lie_line_ram and lie_out_reg.
// Usage
//   in_*  : one received terminal byte per beat (in_tdata[7:0]).
//   out_* : result beats; tdata[7:0] byte, tdata[12:8] line length,
//           tuser kind (0 echo, 1 line content), tlast on the final beat
//           caused by one input byte.
//   An ordinary byte is stored and echoed while the store has room.
//   Backspace/delete removes one byte and echoes BS, space, BS.
//   CR/LF on a non-empty line echoes CR, LF, then sends the line.
// Timing
//   One byte at a time: in_tready is high only while the sequencer idles.
//   The first result beat is offered from the sequencer state and held in the
//   output register. Line bytes stream at one per cycle from the line store
//   read port while the receiver does not stall.
// Reset and stalls
//   Reset empties the line (fill count zero); store contents are left as is.
//   When the receiver stalls, the output register holds its beat and the
//   sequencer waits; no beat is lost.
module line_input_editor #(
  parameter int LINE_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [12:8] line_length, [15:13] zero
  output logic        out_tuser,  // [0] out_kind
  output logic        out_tlast   // last
);
  import lie_pkg::*;

  localparam int DEPTH = LINE_BYTES - 1;
  localparam int CW    = $clog2(LINE_BYTES);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] CAP = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_CHAR, S_BS1, S_BS2, S_BS3, S_CR, S_LF, S_LINE
  } state_t;

  state_t        state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] len_r;
  logic [CW-1:0] idx_r;
  logic [7:0]    char_r;

  logic          accept;
  logic          is_eol, is_bs;
  logic          push_valid, push_ready, push;
  out_beat_t     beat;
  logic          line_last;
  logic [CW-1:0] idx_inc;
  logic [5:0]    len_ext;
  logic          wr_en, rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // input byte decode
  always_comb begin
    is_eol = 1'b0;
    is_bs  = 1'b0;
    unique case (in_tdata) inside
      CHAR_CR, CHAR_LF:  is_eol = 1'b1;
      CHAR_BS, CHAR_DEL: is_bs  = 1'b1;
      default: ;
    endcase
  end

  assign idx_inc   = idx_r + 1'b1;
  assign line_last = (idx_inc == len_r);
  assign len_ext   = 6'(len_r);

  // beat offered to the output register
  always_comb begin
    push_valid = 1'b1;
    beat.data  = char_r;
    beat.kind  = KIND_ECHO;
    beat.len   = '0;
    beat.last  = 1'b0;
    unique case (state_r)
      S_IDLE: push_valid = 1'b0;
      S_CHAR: beat.last = 1'b1;
      S_BS1:  beat.data = CHAR_BS;
      S_BS2:  beat.data = CHAR_SP;
      S_BS3: begin
        beat.data = CHAR_BS;
        beat.last = 1'b1;
      end
      S_CR:   beat.data = CHAR_CR;
      S_LF:   beat.data = CHAR_LF;
      S_LINE: begin
        beat.data = rd_data;
        beat.kind = KIND_LINE;
        beat.len  = len_ext[LEN_W-1:0];
        beat.last = line_last;
      end
      default: push_valid = 1'b0;
    endcase
  end

  assign push = push_valid && push_ready;

  // store ports: write ordinary bytes, prefetch entry 0 at line end,
  // then fetch the next entry as each line beat is taken
  assign wr_en   = accept && !is_eol && !is_bs && (count_r < CAP);
  assign rd_en   = (accept && is_eol && (count_r != '0)) ||
                   ((state_r == S_LINE) && push && !line_last);
  assign rd_addr = (state_r == S_LINE) ? idx_inc[AW-1:0] : '0;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            char_r <= in_tdata;
            if (is_eol) begin
              if (count_r != '0) begin
                len_r   <= count_r;
                idx_r   <= '0;
                state_r <= S_CR;
              end
            end else if (is_bs) begin
              if (count_r != '0) begin
                count_r <= count_r - 1'b1;
                state_r <= S_BS1;
              end
            end else if (count_r < CAP) begin
              count_r <= count_r + 1'b1;
              state_r <= S_CHAR;
            end
          end
        end
        S_CHAR: if (push) state_r <= S_IDLE;
        S_BS1:  if (push) state_r <= S_BS2;
        S_BS2:  if (push) state_r <= S_BS3;
        S_BS3:  if (push) state_r <= S_IDLE;
        S_CR:   if (push) state_r <= S_LF;
        S_LF:   if (push) state_r <= S_LINE;
        S_LINE: begin
          if (push) begin
            if (line_last) begin
              count_r <= '0;
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_inc;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  lie_line_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lie_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_beat  (beat),
    .push_ready (push_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### bench/line_input_editor_test.sv
// Self-checking bench for line_input_editor: random terminal bytes, lines with edits.
// A tracker class predicts every echo and line-content beat from the bytes accepted.
// Depends on lie_pkg and the line_input_editor RTL.
`timescale 1ns / 100ps

module line_input_editor_test;
  import lie_pkg::*;

  localparam int LINE_BYTES = 32;
  localparam int ITEM_TARGET = 480;
  localparam int IDLE_PCT = 37;

  // Predicts the beats each accepted byte causes and checks them in order
  class echo_line_tracker;
    logic [7:0] typed_chars[];
    int unsigned fill;
    int unsigned cap;
    out_beat_t pending_beats[$];
    int mismatches;
    int edits_applied;

    function new(int unsigned store_cap);
      typed_chars = new[store_cap];
      cap = store_cap;
      fill = 0;
      mismatches = 0;
      edits_applied = 0;
    endfunction

    function void push_beat(logic [7:0] b, logic k, logic [LEN_W-1:0] n, logic lst);
      out_beat_t beat;
      beat.data = b;
      beat.kind = k;
      beat.len = n;
      beat.last = lst;
      pending_beats.push_back(beat);
    endfunction

    // Accepted input byte: update line state and queue the expected beats
    function void take_rx_byte(logic [7:0] rx);
      if (rx == CHAR_CR || rx == CHAR_LF) begin
        if (fill == 0) return;
        push_beat(CHAR_CR, KIND_ECHO, '0, 1'b0);
        push_beat(CHAR_LF, KIND_ECHO, '0, 1'b0);
        for (int i = 0; i < fill; i++)
          push_beat(typed_chars[i], KIND_LINE, fill[LEN_W-1:0], (i == fill - 1));
        fill = 0;
        edits_applied++;
      end else if (rx == CHAR_BS || rx == CHAR_DEL) begin
        if (fill == 0) return;
        fill--;
        push_beat(CHAR_BS, KIND_ECHO, '0, 1'b0);
        push_beat(CHAR_SP, KIND_ECHO, '0, 1'b0);
        push_beat(CHAR_BS, KIND_ECHO, '0, 1'b1);
        edits_applied++;
      end else if (fill < cap) begin
        typed_chars[fill] = rx;
        fill++;
        push_beat(rx, KIND_ECHO, '0, 1'b1);
        edits_applied++;
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Accepted output beat: compare with the oldest expectation
    function void check_out_beat(logic [15:0] tdata, logic tuser, logic tlast);
      out_beat_t want;
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: tdata 0x%0h tuser %0b tlast %0b", tdata, tuser, tlast);
        mismatches++;
        return;
      end
      want = pending_beats.pop_front();
      compare_field("out_byte", want.data, tdata[7:0]);
      compare_field("line_length", 8'(want.len), 8'(tdata[12:8]));
      compare_field("tdata_pad", 8'h00, 8'(tdata[15:13]));
      compare_field("out_kind", 8'(want.kind), 8'(tuser));
      compare_field("last", 8'(want.last), 8'(tlast));
    endfunction

    function int pending();
      return pending_beats.size();
    endfunction

    function void flag_leftovers();
      if (pending_beats.size() != 0) begin
        $error("%0d expected beats never arrived", pending_beats.size());
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  echo_line_tracker tracker;
  bit no_idle;

  line_input_editor #(
    .LINE_BYTES(LINE_BYTES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver side: random stalls unless in a steady stretch
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Beat monitor: results first, then the input taken on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) tracker.check_out_beat(out_tdata, out_tuser, out_tlast);
      if (in_tvalid && in_tready) tracker.take_rx_byte(in_tdata);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken,
  // with tvalid left high so back-to-back beats need no extra step
  task automatic send_byte(input logic [7:0] b);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the sender until every expected beat has come back
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
  endtask

  function automatic logic [7:0] ordinary_byte();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CHAR_CR || b == CHAR_LF || b == CHAR_BS || b == CHAR_DEL);
    return b;
  endfunction

  function automatic logic [7:0] line_end_byte();
    return $urandom_range(1) ? CHAR_CR : CHAR_LF;
  endfunction

  function automatic logic [7:0] erase_byte();
    return $urandom_range(1) ? CHAR_BS : CHAR_DEL;
  endfunction

  // Typed line with occasional erasures, then a line end
  task automatic send_line(input int unsigned chars);
    for (int i = 0; i < chars; i++) begin
      if ($urandom_range(9) == 0) send_byte(erase_byte());
      else send_byte(ordinary_byte());
    end
    send_byte(line_end_byte());
  endtask

  initial begin
    int waited;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    no_idle = 1'b0;
    tracker = new(LINE_BYTES - 1);
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: line ends and erasures on an empty line give nothing
    send_byte(CHAR_CR);
    send_byte(CHAR_BS);
    send_byte(CHAR_DEL);
    send_byte(CHAR_LF);
    // Extreme bytes, both erase codes, then a short line
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h61);
    send_byte(CHAR_DEL);
    send_byte(8'h80);
    send_byte(CHAR_BS);
    send_byte(8'h7E);
    send_byte(CHAR_CR);
    // One-byte line ended by LF
    send_byte(8'h01);
    send_byte(CHAR_LF);
    wait_results_drained();

    // Full store: fill every entry, overflow bytes are dropped, erase, refill
    for (int i = 0; i < LINE_BYTES + 2; i++) send_byte(ordinary_byte());
    send_byte(CHAR_DEL);
    send_byte(8'h00);
    send_byte(8'h55);
    send_byte(CHAR_CR);

    // Random part: mostly well-formed lines, some noise
    while (tracker.edits_applied < ITEM_TARGET) begin
      no_idle = (tracker.edits_applied >= 180 && tracker.edits_applied < 260);
      case ($urandom_range(9))
        0, 1: begin
          for (int i = $urandom_range(1, 6); i > 0; i--) send_byte(8'($urandom));
        end
        2: send_line($urandom_range(LINE_BYTES - 3, LINE_BYTES + 8));
        default: send_line($urandom_range(1, 10));
      endcase
      if ($urandom_range(19) == 0) wait_results_drained();
    end
    no_idle = 1'b0;

    // Let the last results come back, with a bound
    in_tvalid <= 1'b0;
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while (tracker.pending() != 0 && waited < 20000);
    repeat (LINE_BYTES + 8) @(negedge clk);
    tracker.flag_leftovers();

    if (tracker.mismatches == 0) begin
      $display("line_input_editor regression: pass");
    end else begin
      $display("line_input_editor regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("line_input_editor regression: fail");
    $finish;
  end

endmodule

### line_input_editor.f
rtl/core/lie_pkg.sv
rtl/core/lie_line_ram.sv
rtl/core/lie_out_reg.sv
rtl/core/line_input_editor.sv
bench/line_input_editor_test.sv
